FILE: src/rlmp_pkg.sv
// Shared widths and character codes for the range list membership parser.
`default_nettype none

package rlmp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned NUM_W  = 32;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [NUM_W-1:0]  num_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  // Open-ended high bound.
  localparam num_t NUM_ALL_ONES = '1;

endpackage

`default_nettype wire

FILE: src/rlmp_if.sv
// Valid/ready channel interfaces for the character stream and the result.
`default_nettype none

interface rlmp_in_if import rlmp_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;
  num_t  query_value;
  logic  last;

  modport source (output valid, output character, output query_value, output last,
                  input ready);
  modport sink   (input valid, input character, input query_value, input last,
                  output ready);
endinterface

interface rlmp_out_if ();
  logic valid;
  logic ready;
  logic matched;
  logic truncated;

  modport source (output valid, output matched, output truncated, input ready);
  modport sink   (input valid, input matched, input truncated, output ready);
endinterface

`default_nettype wire

FILE: src/range_list_membership_parser_core.sv
// Range list membership parser: streams list text and flags query membership.
//
// Feed a range list such as "1-5, 9,-20,30-" one byte per transaction on in_ch,
// with the query number on the first byte of each list and last set on the
// final byte; exactly one result per list comes out on out_ch (matched,
// truncated). Tokens split on comma or space; "N" matches on equality,
// "A-B" is an inclusive range, "-B" means 0..B, a missing or zero high bound
// means 0xFFFFFFFF. NUL bytes are skipped (an empty list is a single NUL byte
// with last set). Only the first MAX_CHARS non-NUL bytes are parsed; later
// ones set truncated. Throughput is one byte per clock, sustained, while
// out_ch keeps up. A list's last byte goes into the input register, then the
// parse/compare stage loads the result register that drives out_ch.valid. The
// per-byte path is one multiply-by-ten add on the 32-bit token number followed
// by the bound compare. in_ch.ready drops only when a list end sits in the
// input register while an untaken result blocks the output register.
`default_nettype none

module range_list_membership_parser_core import rlmp_pkg::*; #(
  parameter int unsigned MAX_CHARS = 255
) (
  input  wire          clk,
  input  wire          rst_n,
  rlmp_in_if.sink      in_ch,
  rlmp_out_if.source   out_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_LOW,
    PH_SCAN,
    PH_HIGH,
    PH_REST
  } phase_t;

  // input register
  logic             s1_vld_r;
  char_t            s1_char_r;
  num_t             s1_query_r;
  logic             s1_last_r;

  // parser state
  num_t             query_hold_r, query_hold_nxt;
  num_t             first_r, first_nxt;
  num_t             second_r, second_nxt;
  phase_t           phase_r, phase_nxt;
  logic             lowdig_r, lowdig_nxt;
  logic             dash_r, dash_nxt;
  logic             match_r, match_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             open_r, open_nxt;

  // result register
  logic             out_vld_r;
  logic             out_match_r;
  logic             out_trunc_r;

  logic             s1_go;
  logic             s1_take;

  // parse intermediates
  logic             is_digit, is_dash, is_sep, parse;
  logic [3:0]       digit;
  num_t             q_eff;
  num_t             first_x10, second_x10;
  num_t             p_first, p_second;
  phase_t           p_phase;
  logic             p_lowdig, p_dash;
  num_t             ev_first, ev_second, ev_hi;
  phase_t           ev_phase;
  logic             ev_dash;
  logic             do_close, hit, res_match;

  // A list end cannot move on while a result is still waiting.
  assign s1_go   = s1_vld_r && !(s1_last_r && out_vld_r && !out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_go;
  assign s1_take = in_ch.valid && in_ch.ready;

  always_comb begin
    is_digit = s1_char_r inside {[CH_ZERO:CH_NINE]};
    digit    = is_digit ? s1_char_r[3:0] : 4'd0;
    is_dash  = (s1_char_r == CH_DASH);
    is_sep   = (s1_char_r == CH_COMMA) || (s1_char_r == CH_SPACE);
    parse    = (s1_char_r != CH_NUL) && (cnt_r < CNT_W'(MAX_CHARS));

    q_eff = open_r ? query_hold_r : s1_query_r;

    // x*10 + d as two shifted terms plus the digit
    first_x10  = {first_r[NUM_W-4:0], 3'b000} + {first_r[NUM_W-2:0], 1'b0}
               + NUM_W'(digit);
    second_x10 = {second_r[NUM_W-4:0], 3'b000} + {second_r[NUM_W-2:0], 1'b0}
               + NUM_W'(digit);

    p_first  = first_r;
    p_second = second_r;
    p_phase  = phase_r;
    p_lowdig = lowdig_r;
    p_dash   = dash_r;

    if (parse) begin
      if (is_sep) begin
        p_first  = '0;
        p_second = '0;
        p_phase  = PH_BETWEEN;
        p_lowdig = 1'b0;
        p_dash   = 1'b0;
      end else begin
        case (phase_r)
          PH_BETWEEN: begin
            if (is_dash) begin
              p_dash  = 1'b1;
              p_phase = PH_HIGH;
            end else if (is_digit) begin
              p_first  = NUM_W'(digit);
              p_lowdig = 1'b1;
              p_phase  = PH_LOW;
            end else begin
              p_phase = PH_SCAN;
            end
          end
          PH_LOW: begin
            if (is_digit) begin
              p_first = first_x10;
            end else if (is_dash) begin
              p_dash  = 1'b1;
              p_phase = PH_HIGH;
            end else begin
              p_phase = PH_SCAN;
            end
          end
          PH_SCAN: begin
            if (is_dash) begin
              p_dash  = 1'b1;
              p_phase = PH_REST;
            end
          end
          PH_HIGH: begin
            if (is_digit) begin
              p_second = second_x10;
            end else begin
              p_phase = PH_REST;
            end
          end
          default: ;
        endcase
      end
    end

    // One token closes per byte: the current one on a separator, else the
    // updated one at list end (after a separator nothing is open anyway).
    do_close = (parse && is_sep) || s1_last_r;
    if (parse && is_sep) begin
      ev_first  = first_r;
      ev_second = second_r;
      ev_phase  = phase_r;
      ev_dash   = dash_r;
    end else begin
      ev_first  = p_first;
      ev_second = p_second;
      ev_phase  = p_phase;
      ev_dash   = p_dash;
    end
    ev_hi = (ev_second == '0) ? NUM_ALL_ONES : ev_second;
    hit   = (ev_phase != PH_BETWEEN) &&
            (ev_dash ? ((ev_first <= q_eff) && (ev_hi >= q_eff))
                     : (ev_first == q_eff));
    res_match = match_r || (do_close && hit);

    ovf_nxt = ovf_r || ((s1_char_r != CH_NUL) && !parse);

    if (s1_last_r) begin
      query_hold_nxt = '0;
      first_nxt      = '0;
      second_nxt     = '0;
      phase_nxt      = PH_BETWEEN;
      lowdig_nxt     = 1'b0;
      dash_nxt       = 1'b0;
      match_nxt      = 1'b0;
      cnt_nxt        = '0;
      open_nxt       = 1'b0;
    end else begin
      query_hold_nxt = q_eff;
      first_nxt      = p_first;
      second_nxt     = p_second;
      phase_nxt      = p_phase;
      lowdig_nxt     = p_lowdig;
      dash_nxt       = p_dash;
      match_nxt      = res_match;
      cnt_nxt        = parse ? cnt_r + CNT_W'(1) : cnt_r;
      open_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      query_hold_r <= '0;
      first_r      <= '0;
      second_r     <= '0;
      phase_r      <= PH_BETWEEN;
      lowdig_r     <= 1'b0;
      dash_r       <= 1'b0;
      match_r      <= 1'b0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      open_r       <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_vld_r   <= 1'b1;
        s1_char_r  <= in_ch.character;
        s1_query_r <= in_ch.query_value;
        s1_last_r  <= in_ch.last;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end

      // a new list end refills the result slot even as the old one leaves
      if (s1_go && s1_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      if (s1_go) begin
        query_hold_r <= query_hold_nxt;
        first_r      <= first_nxt;
        second_r     <= second_nxt;
        phase_r      <= phase_nxt;
        lowdig_r     <= lowdig_nxt;
        dash_r       <= dash_nxt;
        match_r      <= match_nxt;
        cnt_r        <= cnt_nxt;
        ovf_r        <= s1_last_r ? 1'b0 : ovf_nxt;
        open_r       <= open_nxt;
        if (s1_last_r) begin
          out_match_r <= res_match;
          out_trunc_r <= ovf_nxt;
        end
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.matched   = out_match_r;
  assign out_ch.truncated = out_trunc_r;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHARS))
    else $error("char count past limit");

  a_idle_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BETWEEN) |-> (!lowdig_r && !dash_r && first_r == '0 && second_r == '0))
    else $error("token state not cleared between tokens");

  a_high_has_dash: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HIGH || phase_r == PH_REST) |-> dash_r)
    else $error("high bound phase without dash");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (!open_r && cnt_r == '0 && !match_r && !ovf_r && out_vld_r))
    else $error("list end did not restart parser or load result");

  a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_match_r)
                                      && $stable(out_trunc_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
